FILE: hdl/cmf_pkg.sv
// shared constants, types and helper functions of the cross mean filter
`default_nettype none

package cmf_pkg;

	localparam int CH_W           = 8;
	localparam int NUM_CH         = 3;
	localparam int PIX_W          = CH_W * NUM_CH;
	localparam int DIM_W          = 11;
	localparam int SUM_W          = CH_W + 3;
	localparam int DATA_W         = 32;
	localparam int ADDR_W_CFG     = 3;
	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;

	localparam logic [DIM_W-1:0] RST_WIDTH  = DIM_W'(640);
	localparam logic [DIM_W-1:0] RST_HEIGHT = DIM_W'(480);

	localparam logic REQ_PIXEL = 1'b0;
	localparam logic REQ_DRAIN = 1'b1;

	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	// reciprocal of five, exact for sums up to five full-scale channels
	localparam int RECIP5   = 3277;
	localparam int RECIP5_W = 12;
	localparam int RECIP5_SH = 14;

	typedef logic [CH_W-1:0]  chan_t;
	typedef logic [PIX_W-1:0] pix_t;
	typedef logic [DIM_W-1:0] dim_t;
	typedef logic [SUM_W-1:0] sum_t;

	function automatic dim_t clamp_dim(input dim_t v, input int maxv);
		dim_t r;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (32'(v) > maxv) begin
			r = DIM_W'(maxv);
		end else begin
			r = v;
		end
		return r;
	endfunction

	function automatic chan_t div5(input sum_t s);
		logic [SUM_W+RECIP5_W-1:0] p;
		p = (SUM_W + RECIP5_W)'(s) * (SUM_W + RECIP5_W)'(RECIP5);
		return p[RECIP5_SH +: CH_W];
	endfunction

endpackage

`default_nettype wire

FILE: hdl/cross_mean_filter_rgb_unit.sv
// Usage: five-point cross mean filter over a raster stream of three-channel
// 8-bit pixels. Request beats (req_valid/req_ready) carry req_type and the
// pixel; req_type = 0 is a pixel, 1 a drain beat. Result beats
// (rsp_valid/rsp_ready) carry the filtered pixel and frame_end on the last
// pixel of the frame. Result k of a frame is produced by the pixel beat
// k + frame_width + 1; the final frame_width + 1 results are pushed out by
// drain beats once the whole frame is in. Pixel beats past the frame end
// and drain beats before it give no result.
// Pipeline: an accepted beat goes through stage 1, stage 2 and the output
// register. Throughput: one beat per cycle while rsp_ready keeps up, set by
// the line store, which takes one write and two reads each cycle.
// The APB port holds frame_width (0x0) and frame_height (0x4); a write
// restarts the frame. Reset restores 640 x 480 and empties the pipeline;
// the line store is not cleared. When rsp_ready is low the output register
// holds its beat while the two pipeline stages behind it keep filling;
// req_ready drops only once both are occupied.
`default_nettype none

module cross_mean_filter_rgb_unit
	import cmf_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [ADDR_W_CFG-1:0] paddr,
	input  wire logic [DATA_W-1:0]     pwdata,
	output logic      [DATA_W-1:0]     prdata,
	output logic                       pready,
	input  wire logic                  req_valid,
	output logic                       req_ready,
	input  wire logic                  req_type,
	input  wire logic [CH_W-1:0]       chan0_in,
	input  wire logic [CH_W-1:0]       chan1_in,
	input  wire logic [CH_W-1:0]       chan2_in,
	output logic                       rsp_valid,
	input  wire logic                  rsp_ready,
	output logic      [CH_W-1:0]       chan0_out,
	output logic      [CH_W-1:0]       chan1_out,
	output logic      [CH_W-1:0]       chan2_out,
	output logic                       frame_end
);

	localparam int DEPTH  = 2 * MAX_WIDTH + 2;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int XW     = ((ADDR_W > DIM_W) ? ADDR_W : DIM_W) + 1;

	typedef logic [ADDR_W-1:0] addr_t;

	// configuration
	dim_t w_q, h_q;
	logic cfg_wr;

	// stream position
	dim_t  in_col_q, in_row_q, out_col_q, out_row_q;
	addr_t wa_q, ja_q;
	pix_t  prev_pix_q;

	// line store and window
	pix_t mem [DEPTH];
	pix_t rda_q, rdb_q;
	pix_t l_q, c_q;

	// pipeline
	logic  v_s1, border_s1, fend_s1;
	pix_t  down_s1;
	logic  v_s2, border_s2, fend_s2;
	pix_t  ctr_s2;
	sum_t  sum_s2 [NUM_CH];
	logic  rsp_valid_q, fend_q;
	chan_t ch_q [NUM_CH];

	logic  out_adv, s2_free, s1_free, acc;
	logic  frame_done, is_pixel, pix_take, emit, fend_now, border_now;
	logic  in_col_last, out_col_last, out_row_last;
	addr_t ra_a, ra_b, j1, jw, wa_next;
	pix_t  pix_in, ctr_s1;
	sum_t  sum_s1 [NUM_CH];
	logic [XW-1:0] ja_x, w_x;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_comb begin
		prdata = '0;
		unique case (paddr[2])
			REG_WIDTH:  prdata = DATA_W'(w_q);
			REG_HEIGHT: prdata = DATA_W'(h_q);
			default:    prdata = '0;
		endcase
	end

	// handshake
	assign out_adv   = !rsp_valid_q || rsp_ready;
	assign s2_free   = !v_s2 || out_adv;
	assign s1_free   = !v_s1 || s2_free;
	assign req_ready = s1_free;
	assign acc       = req_valid && req_ready;

	// item decode
	assign frame_done   = (in_row_q == h_q);
	assign is_pixel     = (req_type == REQ_PIXEL);
	assign pix_take     = acc && is_pixel && !frame_done;
	assign in_col_last  = (in_col_q == w_q - 1'b1);
	assign out_col_last = (out_col_q == w_q - 1'b1);
	assign out_row_last = (out_row_q == h_q - 1'b1);
	assign fend_now     = out_row_last && out_col_last;
	assign border_now   = (out_row_q == '0) || out_row_last || (out_col_q == '0) || out_col_last;
	assign pix_in       = {chan2_in, chan1_in, chan0_in};

	always_comb begin
		emit = 1'b0;
		if (acc) begin
			if (is_pixel) begin
				emit = !frame_done && ((in_row_q >= DIM_W'(2)) ||
					((in_row_q == DIM_W'(1)) && (in_col_q != '0)));
			end else begin
				emit = frame_done;
			end
		end
	end

	// line store addresses
	always_comb begin
		ja_x    = XW'(ja_q);
		w_x     = XW'(w_q);
		j1      = (ja_q == addr_t'(DEPTH - 1)) ? '0 : ja_q + 1'b1;
		wa_next = (wa_q == addr_t'(DEPTH - 1)) ? '0 : wa_q + 1'b1;
		if (ja_x >= w_x) begin
			jw = addr_t'(ja_x - w_x);
		end else begin
			jw = addr_t'(ja_x + XW'(DEPTH) - w_x);
		end
		ra_a = j1;
		ra_b = border_now ? ja_q : jw;
	end

	always_ff @(posedge clk) begin
		if (pix_take) begin
			mem[wa_q] <= pix_in;
		end
		if (acc) begin
			rda_q <= mem[ra_a];
			rdb_q <= mem[ra_b];
		end
	end

	// configuration and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q       <= RST_WIDTH;
			h_q       <= RST_HEIGHT;
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			wa_q      <= '0;
			ja_q      <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_WIDTH:  w_q <= clamp_dim(pwdata[DIM_W-1:0], MAX_WIDTH);
				REG_HEIGHT: h_q <= clamp_dim(pwdata[DIM_W-1:0], MAX_HEIGHT);
				default:    w_q <= w_q;
			endcase
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			wa_q      <= '0;
			ja_q      <= '0;
		end else if (emit && fend_now) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			wa_q      <= '0;
			ja_q      <= '0;
		end else begin
			if (pix_take) begin
				wa_q <= wa_next;
				if (in_col_last) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + 1'b1;
				end else begin
					in_col_q <= in_col_q + 1'b1;
				end
			end
			if (emit) begin
				ja_q <= j1;
				if (out_col_last) begin
					out_col_q <= '0;
					out_row_q <= out_row_q + 1'b1;
				end else begin
					out_col_q <= out_col_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pix_take) begin
			prev_pix_q <= pix_in;
		end
	end

	// stage 1: window sums
	assign ctr_s1 = border_s1 ? rdb_q : c_q;

	always_comb begin
		for (int i = 0; i < NUM_CH; i++) begin
			sum_s1[i] = sum_t'(ctr_s1[i*CH_W +: CH_W]) + sum_t'(rdb_q[i*CH_W +: CH_W])
				+ sum_t'(down_s1[i*CH_W +: CH_W]) + sum_t'(l_q[i*CH_W +: CH_W])
				+ sum_t'(rda_q[i*CH_W +: CH_W]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (s1_free) begin
				v_s1 <= emit;
			end
			if (s2_free) begin
				v_s2 <= v_s1;
			end
			if (out_adv) begin
				rsp_valid_q <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			border_s1 <= border_now;
			fend_s1   <= fend_now;
			down_s1   <= prev_pix_q;
		end
		if (s2_free) begin
			border_s2 <= border_s1;
			fend_s2   <= fend_s1;
			ctr_s2    <= ctr_s1;
			for (int i = 0; i < NUM_CH; i++) begin
				sum_s2[i] <= sum_s1[i];
			end
			if (v_s1) begin
				l_q <= ctr_s1;
				c_q <= rda_q;
			end
		end
		if (out_adv) begin
			fend_q <= fend_s2;
			for (int i = 0; i < NUM_CH; i++) begin
				ch_q[i] <= border_s2 ? ctr_s2[i*CH_W +: CH_W] : div5(sum_s2[i]);
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign chan0_out = ch_q[0];
	assign chan1_out = ch_q[1];
	assign chan2_out = ch_q[2];
	assign frame_end = fend_q;

`ifndef SYNTHESIS
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		in_col_q < w_q)
		else $error("input column beyond frame width");

	a_out_behind: assert property (@(posedge clk) disable iff (!arst_n)
		out_row_q <= in_row_q)
		else $error("output row ahead of input row");

	a_addr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(int'(wa_q) < DEPTH) && (int'(ja_q) < DEPTH))
		else $error("line store address out of range");

	a_fend_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && fend_now && !cfg_wr) |=> (in_row_q == '0) && (out_row_q == '0) && (wa_q == '0))
		else $error("frame not restarted after last result");
`endif

endmodule

`default_nettype wire
